// ===== hw/rtl/lcgr_pkg.sv =====
package lcgr_pkg;

	localparam int CRATE_COLS = 8;
	localparam int CRATE_ROWS = 3;
	localparam int BOX_W      = 4;
	localparam int BOX_H      = 5;
	localparam int BOX_SIZE   = BOX_W * BOX_H;

	localparam int CX_W = (CRATE_COLS > 1) ? $clog2(CRATE_COLS) : 1;
	localparam int CY_W = (CRATE_ROWS > 1) ? $clog2(CRATE_ROWS) : 1;
	localparam int SLOT_FULL_W = $clog2(CRATE_COLS * CRATE_ROWS * BOX_SIZE + 1);
	localparam int SLOT_CALC_W = (SLOT_FULL_W > 9) ? SLOT_FULL_W : 9;

	localparam int COLOR_W = 8;
	localparam int SLOT_W  = 9;
	localparam int BRIGHT_W = 9;
	localparam int Q_W     = 17;
	localparam int PROD_W  = 2 * Q_W;
	localparam int SCALE_W = Q_W + BRIGHT_W;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_DATA_W = 9;

	localparam logic REG_BRIGHTNESS = 1'b0;
	localparam logic REG_ALPHA_MODE = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic       take;
		logic       init;
		logic       step;
		logic       scale;
		logic       fin;
		logic       out_load;
		logic [1:0] ch;
		logic [2:0] bit_idx;
	} lcgr_cmd_t;

	typedef struct packed {
		logic out_free;
	} lcgr_status_t;

	// (c*65536 + 127) / 255 == 257*c + (c >= 128)
	function automatic logic [Q_W-1:0] base_of(input logic [COLOR_W-1:0] c);
		logic [Q_W-1:0] b;
		b = {1'b0, c, c} + {{(Q_W-1){1'b0}}, c[7]};
		return b;
	endfunction

	// local bottle position (row*4 + col) to serpentine slot
	function automatic logic [4:0] slot_of_pos(input logic [4:0] pos);
		logic [4:0] s;
		unique case (pos)
			5'd0:  s = 5'd0;
			5'd1:  s = 5'd9;
			5'd2:  s = 5'd10;
			5'd3:  s = 5'd19;
			5'd4:  s = 5'd1;
			5'd5:  s = 5'd8;
			5'd6:  s = 5'd11;
			5'd7:  s = 5'd18;
			5'd8:  s = 5'd2;
			5'd9:  s = 5'd7;
			5'd10: s = 5'd12;
			5'd11: s = 5'd17;
			5'd12: s = 5'd3;
			5'd13: s = 5'd6;
			5'd14: s = 5'd13;
			5'd15: s = 5'd16;
			5'd16: s = 5'd4;
			5'd17: s = 5'd5;
			5'd18: s = 5'd14;
			5'd19: s = 5'd15;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/lcgr_ctrl.sv =====
module lcgr_ctrl import lcgr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         alpha_mode,
	input  lcgr_status_t status,
	output lcgr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_POW   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] ch_q;
	logic [1:0] ch_d;
	logic [2:0] bit_q;
	logic [2:0] bit_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		bit_d   = bit_q;
		cmd     = '0;
		cmd.ch      = ch_q;
		cmd.bit_idx = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					ch_d     = CH_RED;
					state_d  = alpha_mode ? ST_INIT : ST_LOAD;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				bit_d    = 3'd0;
				state_d  = ST_POW;
			end
			ST_POW: begin
				cmd.step = 1'b1;
				bit_d    = bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (ch_q == CH_BLUE) begin
					state_d = ST_LOAD;
				end else begin
					ch_d    = ch_q + 2'd1;
					state_d = ST_INIT;
				end
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= CH_RED;
			bit_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			bit_q   <= bit_d;
		end
	end

endmodule

// ===== hw/rtl/lcgr_datapath.sv =====
module lcgr_datapath import lcgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcgr_cmd_t             cmd,
	output lcgr_status_t          status,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [BRIGHT_W-1:0]   brightness,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	// pixel position
	logic [1:0]      xi_q;
	logic [CX_W-1:0] cx_q;
	logic [2:0]      yi_q;
	logic [CY_W-1:0] cy_q;
	logic            last_px;
	logic [SLOT_CALC_W-1:0] crate_idx;
	logic [SLOT_CALC_W-1:0] slot_full;
	logic [4:0]      local_pos;

	// pixel registers
	logic [COLOR_W-1:0] red_q;
	logic [COLOR_W-1:0] green_q;
	logic [COLOR_W-1:0] blue_q;
	logic [COLOR_W-1:0] gam_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               fend_q;

	// power unit
	logic [Q_W-1:0]     p_q;
	logic [Q_W-1:0]     base_q;
	logic [SCALE_W-1:0] t_q;
	logic [PROD_W-1:0]  prod_pb;
	logic [PROD_W-1:0]  prod_bb;
	logic [PROD_W-1:0]  rnd_pb;
	logic [PROD_W-1:0]  rnd_bb;
	logic [COLOR_W-1:0] ch_sel;
	logic [PROD_W-1:0]  scaled;
	logic [9:0]         v_raw;
	logic [COLOR_W-1:0] v_sat;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	assign last_px = (xi_q == 2'd3) && (cx_q == CX_W'(CRATE_COLS - 1)) &&
		(yi_q == 3'd4) && (cy_q == CY_W'(CRATE_ROWS - 1));
	assign local_pos = {yi_q, 2'b00} + {3'b000, xi_q};
	assign crate_idx = SLOT_CALC_W'(cy_q) * SLOT_CALC_W'(CRATE_COLS) + SLOT_CALC_W'(cx_q);
	assign slot_full = crate_idx * SLOT_CALC_W'(BOX_SIZE) +
		SLOT_CALC_W'(slot_of_pos(local_pos));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xi_q <= '0;
			cx_q <= '0;
			yi_q <= '0;
			cy_q <= '0;
		end else if (cmd.take) begin
			if (xi_q != 2'd3) begin
				xi_q <= xi_q + 2'd1;
			end else begin
				xi_q <= '0;
				if (cx_q != CX_W'(CRATE_COLS - 1)) begin
					cx_q <= cx_q + CX_W'(1);
				end else begin
					cx_q <= '0;
					if (yi_q != 3'd4) begin
						yi_q <= yi_q + 3'd1;
					end else begin
						yi_q <= '0;
						if (cy_q != CY_W'(CRATE_ROWS - 1)) begin
							cy_q <= cy_q + CY_W'(1);
						end else begin
							cy_q <= '0;
						end
					end
				end
			end
		end
	end

	always_comb begin
		unique case (cmd.ch)
			CH_RED:   ch_sel = red_q;
			CH_GREEN: ch_sel = green_q;
			default:  ch_sel = blue_q;
		endcase
	end

	assign prod_pb = p_q * base_q;
	assign prod_bb = base_q * base_q;
	assign rnd_pb  = prod_pb + PROD_W'(32768);
	assign rnd_bb  = prod_bb + PROD_W'(32768);
	assign scaled  = ({t_q, 8'b0} - {8'b0, t_q}) + PROD_W'(8388608);
	assign v_raw   = scaled[33:24];
	assign v_sat   = (v_raw > 10'd255) ? 8'hFF : v_raw[7:0];

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			red_q   <= in_data[7:0];
			green_q <= in_data[15:8];
			blue_q  <= in_data[23:16];
			gam_q   <= in_data[31:24];
			slot_q  <= slot_full[SLOT_W-1:0];
			fend_q  <= last_px;
		end
		if (cmd.init) begin
			base_q <= base_of(ch_sel);
			p_q    <= Q_W'(65536);
		end
		if (cmd.step) begin
			if (gam_q[cmd.bit_idx]) begin
				p_q <= rnd_pb[32:16];
			end
			base_q <= rnd_bb[32:16];
		end
		if (cmd.scale) begin
			t_q <= SCALE_W'(p_q) * SCALE_W'(brightness);
		end
		if (cmd.fin) begin
			unique case (cmd.ch)
				CH_RED:   red_q   <= v_sat;
				CH_GREEN: green_q <= v_sat;
				default:  blue_q  <= v_sat;
			endcase
		end
		if (cmd.out_load) begin
			out_data_q <= {7'b0, blue_q, green_q, red_q, slot_q};
			out_last_q <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== hw/rtl/led_crate_pixel_gamma_remap.sv =====
// Remaps raster-order frame pixels onto the LED crate chain and optionally applies
// per-pixel gamma and brightness. Each request on the input stream is one pixel; its
// frame position comes from an internal counter, so the first pixel after reset is
// the top-left pixel of a frame, and the last pixel of a frame is flagged on tlast.
// With alpha_mode clear a pixel is accepted and then loaded into the output
// register. With alpha_mode set, one shared square-and-multiply unit handles the
// three colors in turn, one exponent bit per cycle, plus set-up, brightness scaling
// and rounding steps for each color. The output register lets a new pixel be
// accepted while the previous result still waits. Configuration writes are always
// ready and must only be issued while no pixel is in flight.
module led_crate_pixel_gamma_remap import lcgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // red, green, blue, gamma_exp
	input  logic                  m_axis_tready,
	output logic                  m_axis_tvalid,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // chain_slot, out_red, out_green, out_blue
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BRIGHT_W-1:0] brightness_q;
	logic                alpha_mode_q;
	lcgr_cmd_t           cmd;
	lcgr_status_t        status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_W'(256);
			alpha_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				default:        alpha_mode_q <= cfg_data[0];
			endcase
		end
	end

	lcgr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.alpha_mode (alpha_mode_q),
		.status     (status),
		.cmd        (cmd)
	);

	lcgr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_data    (s_axis_tdata),
		.brightness (brightness_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
